[rtl/lis_pkg.sv]
// Shared types and constants for the longest-increasing-subsequence block.
package lis_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned LEN_W       = 11;
  localparam int unsigned MAX_LEN_DEF = 1024;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } lis_in_t;

  typedef struct packed {
    logic [LEN_W-1:0] lis_length;
    logic             overflow;
  } lis_out_t;

  // Result of the shared compare unit
  typedef struct packed {
    logic key_gt;
  } lis_cmp_t;

endpackage

[rtl/lis_tail_mem.sv]
// Tail store: one write port, one registered read port.
module lis_tail_mem import lis_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF,
  parameter int unsigned AW      = $clog2(MAX_LEN)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic signed [VALUE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic signed [VALUE_W-1:0] rd_data
);

  logic signed [VALUE_W-1:0] mem [MAX_LEN];
  logic signed [VALUE_W-1:0] rd_data_r;

  // Write the new tail
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the probed tail
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/lis_cmp_unit.sv]
// Shared signed compare of the held key against one tail operand.
module lis_cmp_unit import lis_pkg::*; (
  input  logic signed [VALUE_W-1:0] key,
  input  logic signed [VALUE_W-1:0] operand,
  output lis_cmp_t                  res
);

  // Compare as signed two's complement
  always_comb begin
    res.key_gt = key > operand;
  end

endmodule

[rtl/lis_patience_tails.sv]
// Top level: sequencer running the tail search over the shared compare unit.
// Items are taken one at a time: in_stall stays high until the previous item is done.
// An append is handled in the check step; a replace runs a binary search over the
// tails and then writes, each search step costing one tail store read and one compare.
// On a last item the result register is then loaded, waiting while out_stall holds it.
// Reset (rst_n low, synchronous) empties the tail set, clears the overflow flag
// and drops any pending result; the tail store itself is not cleared.
module lis_patience_tails import lis_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  lis_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output lis_out_t out_data
);

  localparam int unsigned AW    = $clog2(MAX_LEN);
  localparam int unsigned CW    = $clog2(MAX_LEN + 1);
  localparam int unsigned EXT_W = (CW > LEN_W) ? CW : LEN_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_RD    = 6'b000100,
    ST_CMP   = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_EMIT  = 6'b100000
  } lis_state_t;

  lis_state_t                state_r, state_nxt;
  logic signed [VALUE_W-1:0] key_r;
  logic                      last_r;
  logic signed [VALUE_W-1:0] last_tail_r, last_tail_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [AW-1:0]             lo_r, lo_nxt;
  logic [AW-1:0]             hi_r, hi_nxt;
  logic                      out_valid_r, out_valid_nxt;
  lis_out_t                  out_data_r, out_data_nxt;

  logic                      in_fire;
  logic [AW:0]               mid_sum;
  logic [AW-1:0]             mid;
  logic [AW-1:0]             top_idx;
  logic signed [VALUE_W-1:0] rd_data;
  logic signed [VALUE_W-1:0] cmp_operand;
  lis_cmp_t                  cmp_res;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic                      rd_en;
  logic [EXT_W-1:0]          count_ext;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = mid_sum[AW:1];
  assign top_idx   = AW'(count_r - CW'(1));
  assign count_ext = EXT_W'(count_r);

  // Feed the compare unit the probed tail on the compare step, the last tail otherwise
  assign cmp_operand = (state_r == ST_CMP) ? rd_data : last_tail_r;

  lis_cmp_unit u_cmp (
    .key     (key_r),
    .operand (cmp_operand),
    .res     (cmp_res)
  );

  lis_tail_mem #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (key_r),
    .rd_en   (rd_en),
    .rd_addr (mid),
    .rd_data (rd_data)
  );

  // Sequence the check, search and write steps
  always_comb begin
    state_nxt     = state_r;
    last_tail_nxt = last_tail_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = lo_r;
    rd_en         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (count_r == '0 || cmp_res.key_gt) begin
          // Append, or drop it when the store is full
          if (count_r < CW'(MAX_LEN)) begin
            wr_en         = 1'b1;
            wr_addr       = AW'(count_r);
            count_nxt     = count_r + CW'(1);
            last_tail_nxt = key_r;
          end else begin
            ovf_nxt = 1'b1;
          end
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end else begin
          // Answer lies in [0, count-1]
          lo_nxt    = '0;
          hi_nxt    = top_idx;
          state_nxt = (top_idx == '0) ? ST_WRITE : ST_RD;
        end
      end
      ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // Tail below key: move lo past mid, else pull hi down to mid
        if (cmp_res.key_gt) begin
          lo_nxt = mid + AW'(1);
        end else begin
          hi_nxt = mid;
        end
        state_nxt = ((cmp_res.key_gt ? mid + AW'(1) : lo_r) ==
                     (cmp_res.key_gt ? hi_r : mid)) ? ST_WRITE : ST_RD;
      end
      ST_WRITE: begin
        wr_en = 1'b1;
        if (lo_r == top_idx) begin
          last_tail_nxt = key_r;
        end
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // Load the result once the output register is free, then clear
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.lis_length = count_ext[LEN_W-1:0];
          out_data_nxt.overflow   = ovf_r;
          count_nxt               = '0;
          ovf_nxt                 = 1'b0;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload and search bounds
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r  <= in_data.value;
      last_r <= in_data.last;
    end
    last_tail_r <= last_tail_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Tail count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_LEN))
    else $error("tail count above store depth");

  // A search step always has an open interval
  a_search_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD || state_r == ST_CMP) |-> lo_r < hi_r)
    else $error("search interval empty while probing");

  // Search bounds stay inside the written tails
  a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD || state_r == ST_CMP || state_r == ST_WRITE) |->
      (count_r != '0 && {1'b0, hi_r} < (AW+1)'(count_r)))
    else $error("search reaches an unwritten tail");

  // The check step follows only an accepted beat
  a_check_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> $past(in_valid && !in_stall))
    else $error("check step without an accepted beat");

endmodule
